@@ hdl/fpr_pkg.sv @@
package fpr_pkg;

    // field widths of the transaction payloads
    localparam int PAGE_W = 16;
    localparam int MISS_W = 32;
    localparam int CFG_W  = 5;

    // frame count after reset
    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 5'd4;

    // input transaction
    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              sequence_end;
    } t_req;

    // result transaction
    typedef struct packed {
        logic              is_hit;
        logic [PAGE_W-1:0] resident_page;
        logic [MISS_W-1:0] miss_total;
        logic              last_in_list;
    } t_res;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE,
        ST_LIST
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic rewind;
        logic scan;
        logic set_hit;
        logic write;
        logic emit;
        logic finish;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic list_done;
    } t_sts;

endpackage

@@ hdl/fpr_ram.sv @@
module fpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fpr_ctrl.sv @@
module fpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  fpr_pkg::t_sts i_sts,
    output fpr_pkg::t_cmd o_cmd,
    output logic          busy
);
    import fpr_pkg::*;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.hit) begin
                    n_state = ST_LIST;
                end else if (i_sts.miss) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_LIST;
            end
            ST_LIST: begin
                if (i_sts.list_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.rewind = 1'b1;
                end
            end
            ST_SEARCH: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.set_hit = 1'b1;
                    o_cmd.rewind  = 1'b1;
                end
            end
            ST_WRITE: begin
                o_cmd.write  = 1'b1;
                o_cmd.rewind = 1'b1;
            end
            ST_LIST: begin
                o_cmd.scan = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_sts.list_done) begin
                    o_cmd.finish = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a miss always writes once and then lists
    a_write_then_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> (r_state == ST_LIST))
        else $error("write state not followed by list state");

endmodule

@@ hdl/fpr_datapath.sv @@
module fpr_datapath #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpr_pkg::t_cmd                i_cmd,
    output fpr_pkg::t_sts                o_sts,
    input  fpr_pkg::t_req                i_req,
    input  logic [fpr_pkg::CFG_W-1:0]    i_frame_count,
    output logic                         o_res_valid,
    output fpr_pkg::t_res                o_res
);
    import fpr_pkg::*;

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int OCC_W  = $clog2(FRAMES + 1);
    localparam int SUM_W  = OCC_W + 1;

    // slot of the entry ofs places after base, wrapping at FRAMES
    function automatic logic [SLOT_W-1:0] f_slot(input logic [SLOT_W-1:0] base,
                                                 input logic [OCC_W-1:0]  ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(FRAMES)) begin
            sum = sum - SUM_W'(FRAMES);
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_end;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_oldest;
    logic [OCC_W-1:0]     r_occ;
    logic [MISS_W-1:0]    r_miss;
    logic [OCC_W-1:0]     r_idx;
    logic                 r_rvld;
    logic                 r_rlast;

    logic                 n_hit;
    logic [SLOT_W-1:0]    n_oldest;
    logic [OCC_W-1:0]     n_occ;
    logic [MISS_W-1:0]    n_miss;
    logic [OCC_W-1:0]     n_idx;
    logic                 n_rvld;
    logic                 n_rlast;

    logic [PAGE_BITS+PAGE_W-1:0] w_page_ext;
    logic [PAGE_W+PAGE_BITS-1:0] w_res_ext;
    logic [PAGE_BITS-1:0]        w_page;
    logic [PAGE_BITS-1:0]        w_rdata;
    logic [SLOT_W-1:0]           w_raddr;
    logic [SLOT_W-1:0]           w_waddr;
    logic [OCC_W-1:0]            w_limit;
    logic                        w_full;
    logic                        w_re;
    logic                        w_match;

    // page in its stored width
    assign w_page_ext = {{PAGE_BITS{1'b0}}, i_req.page_number};
    assign w_page     = w_page_ext[PAGE_BITS-1:0];

    // frames in use, clamped to 1..FRAMES
    always_comb begin
        if (i_frame_count == '0) begin
            w_limit = OCC_W'(1);
        end else if (32'(i_frame_count) > 32'(FRAMES)) begin
            w_limit = OCC_W'(FRAMES);
        end else begin
            w_limit = OCC_W'(i_frame_count);
        end
    end

    assign w_full  = (r_occ >= w_limit);
    assign w_re    = i_cmd.scan && (r_idx < r_occ);
    assign w_raddr = f_slot(r_oldest, r_idx);
    assign w_waddr = f_slot(r_oldest, r_occ);
    assign w_match = (w_rdata == r_page);

    // page store, walked oldest first
    fpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (w_waddr),
        .i_wdata (r_page),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // status back to the controller
    assign o_sts.hit       = r_rvld && w_match;
    assign o_sts.miss      = (r_rvld && !w_match && r_rlast) || (r_occ == '0);
    assign o_sts.list_done = r_rvld && r_rlast;

    // next values of the table and walk state
    always_comb begin
        n_hit    = r_hit;
        n_oldest = r_oldest;
        n_occ    = r_occ;
        n_miss   = r_miss;
        n_idx    = r_idx;
        n_rvld   = r_rvld;
        n_rlast  = r_rlast;
        if (i_cmd.load) begin
            n_hit = 1'b0;
        end
        if (i_cmd.set_hit) begin
            n_hit = 1'b1;
        end
        if (i_cmd.scan) begin
            n_rvld  = w_re;
            n_rlast = (r_idx == (r_occ - OCC_W'(1)));
            if (w_re) begin
                n_idx = r_idx + OCC_W'(1);
            end
        end
        if (i_cmd.rewind) begin
            n_idx   = '0;
            n_rvld  = 1'b0;
            n_rlast = 1'b0;
        end
        // miss: append, or evict the oldest when full
        if (i_cmd.write) begin
            if (w_full) begin
                n_oldest = f_slot(r_oldest, OCC_W'(1));
            end else begin
                n_occ = r_occ + OCC_W'(1);
            end
            if (r_miss != '1) begin
                n_miss = r_miss + MISS_W'(1);
            end
        end
        // end of sequence clears the table and the miss count
        if (i_cmd.finish && r_end) begin
            n_oldest = '0;
            n_occ    = '0;
            n_miss   = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit    <= 1'b0;
            r_oldest <= '0;
            r_occ    <= '0;
            r_miss   <= '0;
            r_idx    <= '0;
            r_rvld   <= 1'b0;
            r_rlast  <= 1'b0;
        end else begin
            r_hit    <= n_hit;
            r_oldest <= n_oldest;
            r_occ    <= n_occ;
            r_miss   <= n_miss;
            r_idx    <= n_idx;
            r_rvld   <= n_rvld;
            r_rlast  <= n_rlast;
        end
    end

    // captured request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= w_page;
            r_end  <= i_req.sequence_end;
        end
    end

    // result transaction
    assign w_res_ext           = {{PAGE_W{1'b0}}, w_rdata};
    assign o_res_valid         = i_cmd.emit && r_rvld;
    assign o_res.is_hit        = r_hit;
    assign o_res.resident_page = w_res_ext[PAGE_W-1:0];
    assign o_res.miss_total    = r_miss;
    assign o_res.last_in_list  = r_rlast;

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(FRAMES))
        else $error("occupancy above frame count");

    a_oldest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_oldest) < 32'(FRAMES))
        else $error("oldest slot out of range");

    a_write_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> (r_occ != '0))
        else $error("table empty after a miss");

endmodule

@@ hdl/fifo_page_replacement.sv @@
// channel   | direction | transaction at rising edge     | payload
// ----------+-----------+--------------------------------+-------------------------------
// request   | in        | start && !busy                 | i_req (page_number, sequence_end)
// result    | out       | o_res_valid (one cycle, strobe)| o_res (is_hit, resident_page, ...)
// config    | in        | i_cfg_valid && o_cfg_ready     | i_cfg_data (frame_count)
//
// per reference: the search walk reads the stored pages oldest first until a hit or
// the last page (no read if empty), a miss adds a write state, then the listing walk
// reads every resident page and the block returns to idle; both walks share the
// single read port of the page store
// busy is high from the accepted request until the last result has been strobed;
// config is taken only while busy and start are low
// synchronous active-low reset: empty table, zero miss count, frame count 4;
// results cannot be stalled by the receiver
module fifo_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  fpr_pkg::t_req                i_req,
    output logic                         busy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fpr_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_res_valid,
    output fpr_pkg::t_res                o_res
);
    import fpr_pkg::*;

    logic [CFG_W-1:0] r_frame_count;
    t_cmd             w_cmd;
    t_sts             w_sts;

    // configuration register, never alongside a request transaction
    assign o_cfg_ready = !busy && !start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_count <= i_cfg_data;
        end
    end

    // controller
    fpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // datapath
    fpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req         (i_req),
        .i_frame_count (r_frame_count),
        .o_res_valid   (o_res_valid),
        .o_res         (o_res)
    );

endmodule

@@ test/testbench.sv @@
module testbench;
    import fpr_pkg::*;

    localparam int FRAMES        = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 40;

    // dut signals, all inputs known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    t_req               i_req       = '0;
    logic               busy;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               o_res_valid;
    t_res               o_res;

    // page table mirror
    logic [PAGE_W-1:0]  frame_pages [FRAMES];
    logic [3:0]         head_slot    = '0;
    logic [4:0]         resident_cnt = '0;
    logic [MISS_W-1:0]  miss_cnt     = '0;
    logic [CFG_W-1:0]   frame_cfg    = FRAME_COUNT_RST;

    t_req               pending_refs [$];
    t_res               expected_listing [$];
    int                 send_idle_pct = 34;
    int                 error_cnt     = 0;

    fifo_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // frames in use for a given register value
    function automatic int frame_limit_of(input logic [CFG_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > FRAMES)
            return FRAMES;
        return int'(cfg);
    endfunction

    // apply one reference to the mirror and queue the listing it produces
    task automatic predict_reference(input t_req req);
        int         lim;
        bit         hit;
        logic [3:0] slot;
        t_res       res;
        lim = frame_limit_of(frame_cfg);
        hit = 1'b0;
        for (int k = 0; k < resident_cnt; k++) begin
            slot = head_slot + 4'(k);
            if (frame_pages[slot] == req.page_number)
                hit = 1'b1;
        end
        if (!hit) begin
            if (resident_cnt < lim) begin
                slot = head_slot + resident_cnt[3:0];
                frame_pages[slot] = req.page_number;
                resident_cnt++;
            end else begin
                // full: drop the oldest, new page goes to the tail
                head_slot = head_slot + 4'd1;
                slot = head_slot + 4'(resident_cnt - 5'd1);
                frame_pages[slot] = req.page_number;
            end
            if (miss_cnt != '1)
                miss_cnt++;
        end
        for (int k = 0; k < resident_cnt; k++) begin
            slot = head_slot + 4'(k);
            res.is_hit        = hit;
            res.resident_page = frame_pages[slot];
            res.miss_total    = miss_cnt;
            res.last_in_list  = (k == resident_cnt - 1);
            expected_listing.insert(expected_listing.size(), res);
        end
        // end of sequence clears table and count
        if (req.sequence_end) begin
            head_slot    = '0;
            resident_cnt = '0;
            miss_cnt     = '0;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_reference(i_req);
                void'(pending_refs.pop_front());
            end
            if (pending_refs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                start <= 1'b1;
                i_req <= pending_refs[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (expected_listing.size() == 0) begin
                $error("unexpected result transaction, resident_page %0h", o_res.resident_page);
                error_cnt++;
            end else begin
                want = expected_listing.pop_front();
                if (o_res.is_hit !== want.is_hit) begin
                    $error("is_hit: expected %0d, actual %0d", want.is_hit, o_res.is_hit);
                    error_cnt++;
                end
                if (o_res.resident_page !== want.resident_page) begin
                    $error("resident_page: expected %0h, actual %0h",
                           want.resident_page, o_res.resident_page);
                    error_cnt++;
                end
                if (o_res.miss_total !== want.miss_total) begin
                    $error("miss_total: expected %0d, actual %0d",
                           want.miss_total, o_res.miss_total);
                    error_cnt++;
                end
                if (o_res.last_in_list !== want.last_in_list) begin
                    $error("last_in_list: expected %0d, actual %0d",
                           want.last_in_list, o_res.last_in_list);
                    error_cnt++;
                end
            end
        end
    end

    task automatic push_ref(input logic [PAGE_W-1:0] page, input logic seq_end);
        t_req r;
        r.page_number  = page;
        r.sequence_end = seq_end;
        pending_refs.insert(pending_refs.size(), r);
    endtask

    // all references taken, all listings seen, then let the block settle
    task automatic wait_drained();
        while (pending_refs.size() != 0 || expected_listing.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one config transaction
    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        frame_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // mostly references from a small page pool so hits and evictions mix
    task automatic random_phase(input int n);
        logic [PAGE_W-1:0] pool [$];
        int                pool_n;
        logic [PAGE_W-1:0] page;
        pool_n = frame_limit_of(frame_cfg) + $urandom_range(1, 4);
        for (int i = 0; i < pool_n; i++)
            pool.insert(pool.size(), PAGE_W'($urandom_range(0, 65535)));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 85)
                page = pool[$urandom_range(0, pool_n - 1)];
            else
                page = PAGE_W'($urandom_range(0, 65535));
            push_ref(page, (i != n - 1) && ($urandom_range(0, 29) == 0));
        end
    endtask

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("fifo_page_replacement test failed");
        $finish;
    end

    // stimulus sequence
    initial begin
        logic [CFG_W-1:0] cfg_plan [12];
        cfg_plan = '{5'd16, 5'd3, 5'd31, 5'd2, 5'd0, 5'd12, 5'd1, 5'd16, 5'd7, 5'd0, 5'd4, 5'd9};
        cfg_plan[9] = CFG_W'($urandom_range(0, 31));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame count: fill, hit, evict, end of sequence
        push_ref(16'h0000, 1'b0);
        push_ref(16'hFFFF, 1'b0);
        push_ref(16'h0000, 1'b0);
        push_ref(16'h8000, 1'b0);
        push_ref(16'h7FFF, 1'b0);
        push_ref(16'h1234, 1'b0);
        push_ref(16'hFFFF, 1'b0);
        push_ref(16'h0000, 1'b0);
        push_ref(16'h5555, 1'b1);
        push_ref(16'hAAAA, 1'b0);
        push_ref(16'hBBBB, 1'b0);
        push_ref(16'hCCCC, 1'b0);
        wait_drained();

        // single frame, lowered below the current occupancy
        write_frame_count(5'd1);
        push_ref(16'hAAAA, 1'b0);
        push_ref(16'h0001, 1'b0);
        push_ref(16'h0001, 1'b1);
        wait_drained();

        // zero frame count behaves as one frame
        write_frame_count(5'd0);
        push_ref(16'h0002, 1'b0);
        push_ref(16'h0003, 1'b0);
        push_ref(16'h0003, 1'b0);
        wait_drained();

        // random phases over several frame counts, idle rate per third
        for (int p = 0; p < 12; p++) begin
            send_idle_pct = (p < 4) ? 34 : (p < 8) ? 46 : 0;
            write_frame_count(cfg_plan[p]);
            random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (error_cnt == 0)
            $display("fifo_page_replacement test passed");
        else
            $display("fifo_page_replacement test failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/fpr_pkg.sv
hdl/fpr_ram.sv
hdl/fpr_ctrl.sv
hdl/fpr_datapath.sv
hdl/fifo_page_replacement.sv
test/testbench.sv
